FILE: design/rect_hit_test_click_tracker_macros.svh
// Assertion macros used by the checker file of the hit-test block.
`ifndef RECT_HIT_TEST_CLICK_TRACKER_MACROS_SVH
`define RECT_HIT_TEST_CLICK_TRACKER_MACROS_SVH

// Same-cycle implication, clocked on i_clk, off while i_rst_n is low.
`define RHT_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rht assertion failed");

// Next-cycle implication, clocked on i_clk, off while i_rst_n is low.
`define RHT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rht assertion failed");

`endif

FILE: design/rht_pkg.sv
// Package: word types, command codes and scan job codes of the hit-test block.
`default_nettype none
package rht_pkg;

    localparam logic [2:0] CMD_CLEAR    = 3'd0;
    localparam logic [2:0] CMD_REGISTER = 3'd1;
    localparam logic [2:0] CMD_DOWN     = 3'd2;
    localparam logic [2:0] CMD_UP       = 3'd3;
    localparam logic [2:0] CMD_UPDATE   = 3'd4;

    localparam logic [2:0] JOB_HOVER  = 3'd0;
    localparam logic [2:0] JOB_LPRESS = 3'd1;
    localparam logic [2:0] JOB_RPRESS = 3'd2;
    localparam logic [2:0] JOB_LREL   = 3'd3;
    localparam logic [2:0] JOB_RREL   = 3'd4;
    localparam logic [2:0] JOB_WIDGET = 3'd5;

    localparam logic [31:0] EPHEMERAL_BIT = 32'h8000_0000;

    typedef struct packed {
        logic [2:0]         command;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] w;
        logic signed [15:0] h;
        logic [31:0]        tag_id;
        logic               btn_sel;
    } t_in_word;

    typedef struct packed {
        logic [5:0]  zone_slot;
        logic        zone_none;
        logic [31:0] clicked_widget;
        logic [31:0] right_clicked_widget;
        logic [5:0]  pressed_zone;
        logic        pressed_none;
        logic        has_capture;
    } t_out_word;

    typedef struct packed {
        logic       accept;
        logic       start;
        logic [2:0] job;
        logic       load;
    } t_ctl_cmd;

    typedef struct packed {
        logic done;
        logic need;
    } t_dp_sts;

endpackage
`default_nettype wire

FILE: design/rht_if.sv
// Valid/ready channel interfaces for the input and result words.
`default_nettype none
interface rht_in_if import rht_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_word data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface rht_out_if import rht_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_word data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: design/rht_dp.sv
// Datapath: zone memory, scan unit, button latches and result register.
`default_nettype none
module rht_dp import rht_pkg::*; #(
    parameter int MAX_ZONES  = 64,
    parameter int COORD_BITS = 16
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_in_word  i_word,
    input  wire t_ctl_cmd  i_cmd,
    output t_dp_sts        o_sts,
    output t_out_word      o_res
);
    localparam int CB = COORD_BITS;
    localparam int IW = (MAX_ZONES > 1) ? $clog2(MAX_ZONES) : 1;
    localparam int CW = $clog2(MAX_ZONES + 1);

    typedef struct packed {
        logic signed [CB-1:0] x;
        logic signed [CB-1:0] y;
        logic signed [CB-1:0] w;
        logic signed [CB-1:0] h;
        logic [31:0]          widget;
    } t_zone;

    t_zone r_mem [MAX_ZONES];

    logic [CW-1:0] r_cnt;
    logic          r_is_upd;
    logic signed [CB-1:0] r_hx, r_hy;
    logic          r_down [2];
    logic          r_prs  [2];
    logic          r_rel  [2];
    logic signed [CB-1:0] r_px [2];
    logic signed [CB-1:0] r_py [2];
    logic signed [CB-1:0] r_rx [2];
    logic signed [CB-1:0] r_ry [2];
    logic [31:0]   r_orig [2];
    logic [31:0]   r_clk  [2];
    logic [IW-1:0] r_zidx;
    logic          r_znone;
    logic [IW-1:0] r_pz;
    logic          r_pnone;
    logic          r_cap;
    t_out_word     r_out;

    logic          r_act;
    logic [IW-1:0] r_idx;
    logic          r_rd_vld;
    logic [IW-1:0] r_rd_idx;
    t_zone         r_rd;

    logic signed [CB-1:0] w_ix, w_iy, w_iw, w_ih;
    logic signed [CB-1:0] w_qx, w_qy;
    logic signed [CB:0]   w_qx_e, w_qy_e, w_zx_e, w_zy_e, w_xe, w_ye;
    logic          w_wmode, w_match, w_empty, w_done, w_found, w_need;
    logic [31:0]   w_fw, w_eph;
    logic [CW-1:0] w_cnt_m1;
    logic [IW+5:0] w_zidx_x, w_pz_x;
    logic          w_btn;
    logic          w_lcap, w_rcap;

    // Sign-extend to 16+CB bits, then keep CB bits.
    assign w_ix = CB'({{CB{i_word.x[15]}}, i_word.x});
    assign w_iy = CB'({{CB{i_word.y[15]}}, i_word.y});
    assign w_iw = CB'({{CB{i_word.w[15]}}, i_word.w});
    assign w_ih = CB'({{CB{i_word.h[15]}}, i_word.h});
    assign w_btn = i_word.btn_sel;
    assign w_eph = EPHEMERAL_BIT | (32'(r_cnt) + 32'd1);
    assign w_cnt_m1 = r_cnt - CW'(1);

    always_comb begin
        case (i_cmd.job)
            JOB_LPRESS: begin w_qx = r_px[0]; w_qy = r_py[0]; end
            JOB_RPRESS: begin w_qx = r_px[1]; w_qy = r_py[1]; end
            JOB_LREL:   begin w_qx = r_rx[0]; w_qy = r_ry[0]; end
            JOB_RREL:   begin w_qx = r_rx[1]; w_qy = r_ry[1]; end
            default:    begin w_qx = r_hx;    w_qy = r_hy;    end
        endcase
    end

    always_comb begin
        case (i_cmd.job)
            JOB_HOVER:  w_need = 1'b1;
            JOB_LPRESS: w_need = r_prs[0];
            JOB_RPRESS: w_need = r_prs[1];
            JOB_LREL:   w_need = r_rel[0];
            JOB_RREL:   w_need = r_rel[1];
            default:    w_need = 1'b1;
        endcase
    end

    assign w_wmode = (i_cmd.job == JOB_WIDGET);
    assign w_qx_e = {w_qx[CB-1], w_qx};
    assign w_qy_e = {w_qy[CB-1], w_qy};
    assign w_zx_e = {r_rd.x[CB-1], r_rd.x};
    assign w_zy_e = {r_rd.y[CB-1], r_rd.y};
    assign w_xe = w_zx_e + {r_rd.w[CB-1], r_rd.w};
    assign w_ye = w_zy_e + {r_rd.h[CB-1], r_rd.h};

    always_comb begin
        if (w_wmode)
            w_match = (r_rd.widget == r_orig[0]);
        else
            w_match = (w_qx_e >= w_zx_e) && (w_qy_e >= w_zy_e) &&
                      (w_qx_e < w_xe) && (w_qy_e < w_ye);
    end

    // Empty table, or no origin widget to look for: finish at once.
    assign w_empty = i_cmd.start &&
                     ((r_cnt == '0) || (w_wmode && (r_orig[0] == 32'd0)));
    assign w_found = r_rd_vld && w_match;
    assign w_done  = w_empty || w_found || (r_rd_vld && (r_rd_idx == '0));
    assign w_fw    = w_found ? r_rd.widget : 32'd0;
    assign o_sts   = '{done: w_done, need: w_need};

    assign w_lcap = (r_orig[0] != 32'd0) && r_down[0];
    assign w_rcap = (r_orig[1] != 32'd0) && r_down[1];

    // Scan: walk from the newest entry down, one read a cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act    <= 1'b0;
            r_rd_vld <= 1'b0;
        end else if (w_done) begin
            r_act    <= 1'b0;
            r_rd_vld <= 1'b0;
        end else if (i_cmd.start) begin
            r_act    <= 1'b1;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= r_act;
            if (r_act && (r_idx == '0))
                r_act <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start)
            r_idx <= w_cnt_m1[IW-1:0];
        else if (r_act && (r_idx != '0))
            r_idx <= r_idx - IW'(1);
        r_rd     <= r_mem[r_idx];
        r_rd_idx <= r_idx;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && (i_word.command == CMD_REGISTER) &&
            (r_cnt < CW'(MAX_ZONES))) begin
            r_mem[r_cnt[IW-1:0]] <= '{x: w_ix, y: w_iy, w: w_iw, h: w_ih,
                widget: (i_word.tag_id == 32'd0) ? w_eph : i_word.tag_id};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_cap   <= 1'b0;
            for (int b = 0; b < 2; b++) begin
                r_down[b] <= 1'b0;
                r_prs[b]  <= 1'b0;
                r_rel[b]  <= 1'b0;
                r_px[b]   <= '0;
                r_py[b]   <= '0;
                r_rx[b]   <= '0;
                r_ry[b]   <= '0;
                r_orig[b] <= 32'd0;
            end
        end else if (i_cmd.accept) begin
            case (i_word.command)
                CMD_CLEAR: r_cnt <= '0;
                CMD_REGISTER: begin
                    if (r_cnt < CW'(MAX_ZONES))
                        r_cnt <= r_cnt + CW'(1);
                end
                CMD_DOWN: begin
                    if (!r_down[w_btn]) begin
                        r_prs[w_btn] <= 1'b1;
                        r_px[w_btn]  <= w_ix;
                        r_py[w_btn]  <= w_iy;
                    end
                    r_down[w_btn] <= 1'b1;
                end
                CMD_UP: begin
                    if (r_down[w_btn]) begin
                        r_rel[w_btn] <= 1'b1;
                        r_rx[w_btn]  <= w_ix;
                        r_ry[w_btn]  <= w_iy;
                    end
                    r_down[w_btn] <= 1'b0;
                end
                default: ;
            endcase
        end else if (w_done) begin
            case (i_cmd.job)
                JOB_LPRESS: r_orig[0] <= w_fw;
                JOB_RPRESS: r_orig[1] <= w_fw;
                JOB_LREL:   r_orig[0] <= 32'd0;
                JOB_RREL:   r_orig[1] <= 32'd0;
                JOB_WIDGET: begin
                    if (r_is_upd) begin
                        r_cap <= w_lcap || w_rcap;
                        for (int b = 0; b < 2; b++) begin
                            r_prs[b] <= 1'b0;
                            r_rel[b] <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Per-item result fields; no reset needed.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_is_upd <= (i_word.command == CMD_UPDATE);
            r_hx     <= w_ix;
            r_hy     <= w_iy;
            r_clk[0] <= 32'd0;
            r_clk[1] <= 32'd0;
            r_zidx   <= '0;
            r_znone  <= 1'b1;
            if ((i_word.command == CMD_REGISTER) && (r_cnt < CW'(MAX_ZONES))) begin
                r_zidx  <= r_cnt[IW-1:0];
                r_znone <= 1'b0;
            end
        end else if (w_done) begin
            case (i_cmd.job)
                JOB_HOVER: begin
                    r_zidx  <= w_found ? r_rd_idx : '0;
                    r_znone <= !w_found;
                end
                JOB_LREL: begin
                    if ((r_orig[0] != 32'd0) && (w_fw == r_orig[0]))
                        r_clk[0] <= w_fw;
                end
                JOB_RREL: begin
                    if ((r_orig[1] != 32'd0) && (w_fw == r_orig[1]))
                        r_clk[1] <= w_fw;
                end
                JOB_WIDGET: begin
                    r_pz    <= w_found ? r_rd_idx : '0;
                    r_pnone <= !w_found;
                end
                default: ;
            endcase
        end
    end

    // Indices wrap modulo 64.
    assign w_zidx_x = (IW + 6)'(r_zidx);
    assign w_pz_x   = (IW + 6)'(r_pz);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out.zone_slot            <= w_zidx_x[5:0];
            r_out.zone_none            <= r_znone;
            r_out.clicked_widget       <= r_clk[0];
            r_out.right_clicked_widget <= r_clk[1];
            r_out.pressed_zone         <= w_pz_x[5:0];
            r_out.pressed_none         <= r_pnone;
            r_out.has_capture          <= r_cap;
        end
    end

    assign o_res = r_out;

endmodule
`default_nettype wire

FILE: design/rht_ctrl.sv
// Controller: sequences the scan jobs of each word and hands off the result.
`default_nettype none
module rht_ctrl import rht_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic [2:0] i_command,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    input  wire t_dp_sts    i_sts,
    output t_ctl_cmd        o_cmd
);
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_START = 2'd1;
    localparam logic [1:0] ST_WAIT  = 2'd2;
    localparam logic [1:0] ST_OUT   = 2'd3;

    logic [1:0] r_state, n_state;
    logic [2:0] r_job, n_job;
    logic       r_out_vld, n_out_vld;
    logic       w_acc;

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_acc      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_vld;

    always_comb begin
        n_state   = r_state;
        n_job     = r_job;
        n_out_vld = r_out_vld && !i_out_ready;
        o_cmd     = '{accept: w_acc, start: 1'b0, job: r_job, load: 1'b0};
        case (r_state)
            ST_IDLE: begin
                if (w_acc) begin
                    n_job   = (i_command == CMD_UPDATE) ? JOB_HOVER : JOB_WIDGET;
                    n_state = ST_START;
                end
            end
            ST_START: begin
                if (i_sts.need) begin
                    o_cmd.start = 1'b1;
                    // An empty scan finishes in its start cycle.
                    if (i_sts.done) begin
                        if (r_job == JOB_WIDGET)
                            n_state = ST_OUT;
                        else
                            n_job = r_job + 3'd1;
                    end else begin
                        n_state = ST_WAIT;
                    end
                end else begin
                    n_job = r_job + 3'd1;
                end
            end
            ST_WAIT: begin
                if (i_sts.done) begin
                    if (r_job == JOB_WIDGET) begin
                        n_state = ST_OUT;
                    end else begin
                        n_job   = r_job + 3'd1;
                        n_state = ST_START;
                    end
                end
            end
            ST_OUT: begin
                // Hold until the result register is free.
                if (!r_out_vld || i_out_ready) begin
                    o_cmd.load = 1'b1;
                    n_out_vld  = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_job     <= JOB_HOVER;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_job     <= n_job;
            r_out_vld <= n_out_vld;
        end
    end

endmodule
`default_nettype wire

FILE: design/rect_hit_test_click_tracker.sv
// Top level: rectangle hit-test table with left/right click tracking.
//
// i_in carries one command word (clear, register zone, button down/up,
// update); o_out returns exactly one result word per input word.
// One word is in flight at a time: i_in.ready is high only while idle.
// A single scan unit reads one zone entry per cycle:
// clear, register, down, up and unknown commands run only the pressed-widget
// search over the N zones, which ends at once when the table is empty or
// no left-button origin widget is held.
// An update runs up to five point scans and then the widget search.
// The next word is taken at the earliest in the cycle after the result loads.
// The result sits in an output register; a stalled receiver holds it,
// and the next word is taken meanwhile, but its result waits until the
// register is free.
// Reset (synchronous, active low) empties the table, clears all button
// latches, origin widgets and capture, and drops any pending result.
// The zone memory needs no clearing pass: only entries below the fill
// count are ever read.
`default_nettype none
module rect_hit_test_click_tracker import rht_pkg::*; #(
    parameter int MAX_ZONES  = 64,
    parameter int COORD_BITS = 16
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    rht_in_if.sink     i_in,
    rht_out_if.source  o_out
);
    t_ctl_cmd  w_cmd;
    t_dp_sts   w_sts;
    t_out_word w_res;

    rht_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_command   (i_in.data.command),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    rht_dp #(
        .MAX_ZONES  (MAX_ZONES),
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_word  (i_in.data),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts),
        .o_res   (w_res)
    );

    assign o_out.data = w_res;

endmodule
`default_nettype wire

FILE: design/rht_chk.sv
// Port checker for the hit-test block, bound to the top level.
`default_nettype none
`include "rect_hit_test_click_tracker_macros.svh"
module rht_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        i_in_ready,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [5:0]  i_zone_slot,
    input wire logic        i_zone_none,
    input wire logic [5:0]  i_pressed_zone,
    input wire logic        i_pressed_none,
    input wire logic [31:0] i_clicked_widget
);
    `RHT_ASSERT_NEXT(a_one_in_flight, i_in_valid && i_in_ready, !i_in_ready)
    `RHT_ASSERT_IMPL(a_no_zone_idx, i_out_valid && i_zone_none, i_zone_slot == 6'd0)
    `RHT_ASSERT_IMPL(a_no_press_idx, i_out_valid && i_pressed_none, i_pressed_zone == 6'd0)
    `RHT_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_clicked_widget))
endmodule

bind rect_hit_test_click_tracker rht_chk u_rht_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in.valid),
    .i_in_ready       (i_in.ready),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_zone_slot      (o_out.data.zone_slot),
    .i_zone_none      (o_out.data.zone_none),
    .i_pressed_zone   (o_out.data.pressed_zone),
    .i_pressed_none   (o_out.data.pressed_none),
    .i_clicked_widget (o_out.data.clicked_widget)
);
`default_nettype wire
